>>> design/ttyrec_record_to_json_assert.svh
// ----------------------------------------------------------------------------
// ttyrec_record_to_json_assert
// Assertion macros shared by the ttyrec_record_to_json design files.
// ----------------------------------------------------------------------------
`ifndef TTYREC_RECORD_TO_JSON_ASSERT_SVH
`define TTYREC_RECORD_TO_JSON_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TTYREC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ttyrec assertion failed");

// Next-cycle implication.
`define TTYREC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttyrec assertion failed");

`endif

>>> design/ttyrec_pkg.sv
// ----------------------------------------------------------------------------
// ttyrec_pkg
// Shared types, character codes and lookup functions for the ttyrec to JSON
// converter: controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ttyrec_pkg;

   localparam int WORD_W     = 32;
   localparam int DEC_DIGITS = 10;
   localparam int BCD_W      = 4 * DEC_DIGITS;
   localparam int CNT_W      = $clog2(WORD_W);
   localparam int PTR_W      = $clog2(DEC_DIGITS);

   localparam logic [3:0] HDR_LAST_IDX = 4'd11;
   localparam logic [CNT_W-1:0] CONV_LAST_CNT = CNT_W'(WORD_W - 1);
   localparam logic [PTR_W-1:0] DIG_FIRST_PTR = PTR_W'(DEC_DIGITS - 1);

   localparam logic [7:0] ASC_COMMA  = 8'h2C;
   localparam logic [7:0] ASC_LBRACK = 8'h5B;
   localparam logic [7:0] ASC_RBRACK = 8'h5D;
   localparam logic [7:0] ASC_QUOTE  = 8'h22;
   localparam logic [7:0] ASC_BSLASH = 8'h5C;
   localparam logic [7:0] ASC_U      = 8'h75;
   localparam logic [7:0] ASC_ZERO   = 8'h30;
   localparam logic [7:0] ASC_LOWER_A = 8'h61;
   localparam logic [7:0] ASC_SPACE  = 8'h20;

   // What the output register loads.
   typedef enum logic [3:0] {
      CH_COMMA  = 4'd0,
      CH_LBRACK = 4'd1,
      CH_DIGIT  = 4'd2,
      CH_QUOTE  = 4'd3,
      CH_RBRACK = 4'd4,
      CH_BSLASH = 4'd5,
      CH_LETTER = 4'd6,
      CH_U      = 4'd7,
      CH_ZERO   = 4'd8,
      CH_HEXHI  = 4'd9,
      CH_HEXLO  = 4'd10,
      CH_RAW    = 4'd11
   } char_sel_type;

   typedef struct packed {
      logic         hdr_wr;
      logic         pay_wr;
      logic         conv_start;
      logic         conv_sel;     // 0: seconds, 1: microseconds
      logic         conv_step;
      logic         dig_skip;
      logic         dig_emit;
      logic         emit;
      char_sel_type char_sel;
      logic         last;
      logic         set_payload;
      logic         clr_first;
   } ctrl_cmd_type;

   typedef struct packed {
      logic in_payload;
      logic hdr_last;
      logic first_record;
      logic len_zero;
      logic last_byte;
      logic esc_named;
      logic esc_ctrl;
      logic conv_last;
      logic dig_lead;
      logic dig_zero;
      logic dig_ptr_zero;
      logic out_ok;
   } ctrl_sts_type;

   // Letter of a named escape, zero when the byte has none.
   function automatic logic [7:0] esc_letter(input logic [7:0] b);
      logic [7:0] r;
      r = 8'h00;
      unique case (b)
         8'h00:   r = 8'h30;   // \0
         8'h22:   r = 8'h22;
         8'h5C:   r = 8'h5C;
         8'h0A:   r = 8'h6E;   // n
         8'h0D:   r = 8'h72;   // r
         8'h0B:   r = 8'h76;   // v
         8'h09:   r = 8'h74;   // t
         8'h08:   r = 8'h62;   // b
         8'h0C:   r = 8'h66;   // f
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] r;
      if (n < 4'd10) begin
         r = ASC_ZERO + {4'd0, n};
      end else begin
         r = ASC_LOWER_A + {4'd0, n - 4'd10};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> design/ttyrec_record_to_json.sv
// ----------------------------------------------------------------------------
// ttyrec_record_to_json
// Converts a ttyrec byte stream into JSON array body text, one character per
// output word, with payload bytes JSON-escaped.
//
//   channel | direction | ports                                  | word
//   req     | in        | req_valid, req_stall, req_in_byte      | one stream byte
//   rsp     | out       | rsp_valid, rsp_stall, rsp_out_byte,    | one character
//           |           | rsp_last_of_run                        |
//
// Header bytes are taken one per cycle. A plain payload byte is emitted as
// is; a named escape as a backslash and a letter, other control bytes as
// \u00xx; record close adds a quote and a bracket. Completing a header runs
// the bit-serial BCD converter for each timestamp and skips leading zeros.
// Input is stalled while the sequencer still has characters of the current
// word to emit; the last one may wait in the output register while the next
// word is taken. An output stall holds the output register and emit states.
// Reset is synchronous; afterward the first record gets no leading comma.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ttyrec_record_to_json_assert.svh"

module ttyrec_record_to_json (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last_of_run
);

   ttyrec_pkg::ctrl_cmd_type cmd;
   ttyrec_pkg::ctrl_sts_type sts;

   ttyrec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ttyrec_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_in_byte     (req_in_byte),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .cmd             (cmd),
      .sts             (sts)
   );

   // a character that is not the last of its run means more are coming
   `TTYREC_ASSERT_NOW(a_run_blocks_input, clock, reset,
      rsp_valid && rsp_stall && !rsp_last_of_run, req_stall)
   // payload mode always has bytes left to take
   `TTYREC_ASSERT_NOW(a_payload_count, clock, reset, sts.in_payload, !sts.len_zero)
   // the output register is never overwritten while stalled
   `TTYREC_ASSERT_NEXT(a_emit_lands, clock, reset, cmd.emit, rsp_valid)
   `TTYREC_ASSERT_NOW(a_emit_room, clock, reset, cmd.emit, sts.out_ok)

endmodule

`default_nettype wire

>>> design/ttyrec_dp.sv
// ----------------------------------------------------------------------------
// ttyrec_dp
// Datapath: header capture, payload counter, binary to BCD converter
// (shift-add-3, one bit per cycle), escape decode and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttyrec_dp (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [7:0]               req_in_byte,
   input  wire logic                     rsp_stall,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_last_of_run,
   input  wire ttyrec_pkg::ctrl_cmd_type cmd,
   output ttyrec_pkg::ctrl_sts_type      sts
);

   logic [3:0]                          hdr_idx_ff, hdr_idx_in;
   logic [ttyrec_pkg::WORD_W-1:0]       sec_ff, sec_in;
   logic [ttyrec_pkg::WORD_W-1:0]       usec_ff, usec_in;
   logic [ttyrec_pkg::WORD_W-1:0]       left_ff, left_in;
   logic                                in_payload_ff, in_payload_in;
   logic                                first_ff, first_in;
   logic                                last_byte_ff, last_byte_in;
   logic [7:0]                          byte_ff, byte_in;

   logic [ttyrec_pkg::WORD_W-1:0]       bin_ff, bin_in;
   logic [ttyrec_pkg::BCD_W-1:0]        bcd_ff, bcd_in;
   logic [ttyrec_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [ttyrec_pkg::PTR_W-1:0]        ptr_ff, ptr_in;
   logic                                lead_ff, lead_in;

   logic                                out_valid_ff, out_valid_in;
   logic [7:0]                          out_byte_ff, out_byte_in;
   logic                                out_last_ff, out_last_in;

   logic [ttyrec_pkg::BCD_W-1:0]        bcd_adj;
   logic [7:0]                          letter;
   logic [7:0]                          char_val;

   assign letter = ttyrec_pkg::esc_letter(byte_ff);

   // header capture and payload bookkeeping
   always_comb begin
      hdr_idx_in    = hdr_idx_ff;
      sec_in        = sec_ff;
      usec_in       = usec_ff;
      left_in       = left_ff;
      in_payload_in = in_payload_ff;
      first_in      = first_ff;
      last_byte_in  = last_byte_ff;
      byte_in       = byte_ff;
      if (cmd.hdr_wr) begin
         unique case (hdr_idx_ff[3:2])
            2'd0:    sec_in[{hdr_idx_ff[1:0], 3'b000} +: 8]  = req_in_byte;
            2'd1:    usec_in[{hdr_idx_ff[1:0], 3'b000} +: 8] = req_in_byte;
            default: left_in[{hdr_idx_ff[1:0], 3'b000} +: 8] = req_in_byte;
         endcase
         hdr_idx_in = (hdr_idx_ff == ttyrec_pkg::HDR_LAST_IDX) ? 4'd0 : hdr_idx_ff + 4'd1;
      end
      if (cmd.pay_wr) begin
         byte_in      = req_in_byte;
         left_in      = left_ff - ttyrec_pkg::WORD_W'(1);
         last_byte_in = (left_ff == ttyrec_pkg::WORD_W'(1));
         if (left_ff == ttyrec_pkg::WORD_W'(1)) begin
            in_payload_in = 1'b0;
         end
      end
      if (cmd.set_payload) begin
         in_payload_in = 1'b1;
      end
      if (cmd.clr_first) begin
         first_in = 1'b0;
      end
   end

   // shift-add-3: adjust every digit at 5 or more, then shift in one bit
   always_comb begin
      bcd_adj = bcd_ff;
      for (int d = 0; d < ttyrec_pkg::DEC_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      ptr_in  = ptr_ff;
      lead_in = lead_ff;
      if (cmd.conv_start) begin
         bin_in  = cmd.conv_sel ? usec_ff : sec_ff;
         bcd_in  = '0;
         cnt_in  = '0;
         ptr_in  = ttyrec_pkg::DIG_FIRST_PTR;
         lead_in = 1'b1;
      end else if (cmd.conv_step) begin
         bcd_in = {bcd_adj[ttyrec_pkg::BCD_W-2:0], bin_ff[ttyrec_pkg::WORD_W-1]};
         bin_in = {bin_ff[ttyrec_pkg::WORD_W-2:0], 1'b0};
         cnt_in = cnt_ff + ttyrec_pkg::CNT_W'(1);
      end else if (cmd.dig_skip || cmd.dig_emit) begin
         // most significant digit always sits at the top
         bcd_in = {bcd_ff[ttyrec_pkg::BCD_W-5:0], 4'd0};
         ptr_in = ptr_ff - ttyrec_pkg::PTR_W'(1);
         if (cmd.dig_emit) begin
            lead_in = 1'b0;
         end
      end
   end

   always_comb begin
      unique case (cmd.char_sel)
         ttyrec_pkg::CH_COMMA:  char_val = ttyrec_pkg::ASC_COMMA;
         ttyrec_pkg::CH_LBRACK: char_val = ttyrec_pkg::ASC_LBRACK;
         ttyrec_pkg::CH_DIGIT:  char_val = ttyrec_pkg::ASC_ZERO +
                                           {4'd0, bcd_ff[ttyrec_pkg::BCD_W-1 -: 4]};
         ttyrec_pkg::CH_QUOTE:  char_val = ttyrec_pkg::ASC_QUOTE;
         ttyrec_pkg::CH_RBRACK: char_val = ttyrec_pkg::ASC_RBRACK;
         ttyrec_pkg::CH_BSLASH: char_val = ttyrec_pkg::ASC_BSLASH;
         ttyrec_pkg::CH_LETTER: char_val = letter;
         ttyrec_pkg::CH_U:      char_val = ttyrec_pkg::ASC_U;
         ttyrec_pkg::CH_ZERO:   char_val = ttyrec_pkg::ASC_ZERO;
         ttyrec_pkg::CH_HEXHI:  char_val = ttyrec_pkg::hex_char(byte_ff[7:4]);
         ttyrec_pkg::CH_HEXLO:  char_val = ttyrec_pkg::hex_char(byte_ff[3:0]);
         ttyrec_pkg::CH_RAW:    char_val = byte_ff;
         default:               char_val = byte_ff;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = char_val;
         out_last_in  = cmd.last;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_idx_ff    <= 4'd0;
         sec_ff        <= '0;
         usec_ff       <= '0;
         left_ff       <= '0;
         in_payload_ff <= 1'b0;
         first_ff      <= 1'b1;
         last_byte_ff  <= 1'b0;
         cnt_ff        <= '0;
         ptr_ff        <= '0;
         lead_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hdr_idx_ff    <= hdr_idx_in;
         sec_ff        <= sec_in;
         usec_ff       <= usec_in;
         left_ff       <= left_in;
         in_payload_ff <= in_payload_in;
         first_ff      <= first_in;
         last_byte_ff  <= last_byte_in;
         cnt_ff        <= cnt_in;
         ptr_ff        <= ptr_in;
         lead_ff       <= lead_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      sts.in_payload   = in_payload_ff;
      sts.hdr_last     = (hdr_idx_ff == ttyrec_pkg::HDR_LAST_IDX);
      sts.first_record = first_ff;
      sts.len_zero     = (left_ff == '0);
      sts.last_byte    = last_byte_ff;
      sts.esc_named    = (letter != 8'h00);
      sts.esc_ctrl     = (byte_ff < ttyrec_pkg::ASC_SPACE) && (letter == 8'h00);
      sts.conv_last    = (cnt_ff == ttyrec_pkg::CONV_LAST_CNT);
      sts.dig_lead     = lead_ff;
      sts.dig_zero     = (bcd_ff[ttyrec_pkg::BCD_W-1 -: 4] == 4'd0);
      sts.dig_ptr_zero = (ptr_ff == '0);
      sts.out_ok       = !out_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

`default_nettype wire

>>> design/ttyrec_ctrl.sv
// ----------------------------------------------------------------------------
// ttyrec_ctrl
// Sequencer: takes input words, steps through the record opening, the two
// decimal conversions, payload escapes and record closing.
// ----------------------------------------------------------------------------
`default_nettype none

module ttyrec_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire ttyrec_pkg::ctrl_sts_type sts,
   output ttyrec_pkg::ctrl_cmd_type      cmd
);

   typedef enum logic [17:0] {
      ST_IDLE   = 18'b000000000000000001,
      ST_COMMA  = 18'b000000000000000010,
      ST_LBRACK = 18'b000000000000000100,
      ST_CONV_S = 18'b000000000000001000,
      ST_DIG_S  = 18'b000000000000010000,
      ST_SEP_S  = 18'b000000000000100000,
      ST_CONV_U = 18'b000000000001000000,
      ST_DIG_U  = 18'b000000000010000000,
      ST_SEP_U  = 18'b000000000100000000,
      ST_QUOTE  = 18'b000000001000000000,
      ST_ESC1   = 18'b000000010000000000,
      ST_ESC2   = 18'b000000100000000000,
      ST_U0     = 18'b000001000000000000,
      ST_U00    = 18'b000010000000000000,
      ST_HEXHI  = 18'b000100000000000000,
      ST_HEXLO  = 18'b001000000000000000,
      ST_CLOSEQ = 18'b010000000000000000,
      ST_CLOSEB = 18'b100000000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;
   logic      dig_skip;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign dig_skip  = sts.dig_lead && sts.dig_zero && !sts.dig_ptr_zero;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.char_sel = ttyrec_pkg::CH_RAW;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (sts.in_payload) begin
                  cmd.pay_wr = 1'b1;
                  state_in   = ST_ESC1;
               end else begin
                  cmd.hdr_wr = 1'b1;
                  if (sts.hdr_last) begin
                     state_in = sts.first_record ? ST_LBRACK : ST_COMMA;
                  end
               end
            end
         end
         ST_COMMA: begin
            cmd.char_sel = ttyrec_pkg::CH_COMMA;
            if (sts.out_ok) begin
               cmd.emit = 1'b1;
               state_in = ST_LBRACK;
            end
         end
         ST_LBRACK: begin
            cmd.char_sel = ttyrec_pkg::CH_LBRACK;
            if (sts.out_ok) begin
               cmd.emit       = 1'b1;
               cmd.clr_first  = 1'b1;
               cmd.conv_start = 1'b1;
               state_in       = ST_CONV_S;
            end
         end
         ST_CONV_S, ST_CONV_U: begin
            cmd.conv_step = 1'b1;
            if (sts.conv_last) begin
               state_in = (state_ff == ST_CONV_S) ? ST_DIG_S : ST_DIG_U;
            end
         end
         ST_DIG_S, ST_DIG_U: begin
            cmd.char_sel = ttyrec_pkg::CH_DIGIT;
            if (dig_skip) begin
               cmd.dig_skip = 1'b1;
            end else if (sts.out_ok) begin
               cmd.emit     = 1'b1;
               cmd.dig_emit = 1'b1;
               if (sts.dig_ptr_zero) begin
                  state_in = (state_ff == ST_DIG_S) ? ST_SEP_S : ST_SEP_U;
               end
            end
         end
         ST_SEP_S: begin
            cmd.char_sel = ttyrec_pkg::CH_COMMA;
            if (sts.out_ok) begin
               cmd.emit       = 1'b1;
               cmd.conv_start = 1'b1;
               cmd.conv_sel   = 1'b1;
               state_in       = ST_CONV_U;
            end
         end
         ST_SEP_U: begin
            cmd.char_sel = ttyrec_pkg::CH_COMMA;
            if (sts.out_ok) begin
               cmd.emit = 1'b1;
               state_in = ST_QUOTE;
            end
         end
         ST_QUOTE: begin
            cmd.char_sel = ttyrec_pkg::CH_QUOTE;
            cmd.last     = !sts.len_zero;
            if (sts.out_ok) begin
               cmd.emit = 1'b1;
               if (sts.len_zero) begin
                  state_in = ST_CLOSEQ;
               end else begin
                  cmd.set_payload = 1'b1;
                  state_in        = ST_IDLE;
               end
            end
         end
         ST_ESC1: begin
            if (sts.esc_named || sts.esc_ctrl) begin
               cmd.char_sel = ttyrec_pkg::CH_BSLASH;
            end else begin
               cmd.char_sel = ttyrec_pkg::CH_RAW;
               cmd.last     = !sts.last_byte;
            end
            if (sts.out_ok) begin
               cmd.emit = 1'b1;
               if (sts.esc_named || sts.esc_ctrl) begin
                  state_in = ST_ESC2;
               end else begin
                  state_in = sts.last_byte ? ST_CLOSEQ : ST_IDLE;
               end
            end
         end
         ST_ESC2: begin
            if (sts.esc_named) begin
               cmd.char_sel = ttyrec_pkg::CH_LETTER;
               cmd.last     = !sts.last_byte;
            end else begin
               cmd.char_sel = ttyrec_pkg::CH_U;
            end
            if (sts.out_ok) begin
               cmd.emit = 1'b1;
               if (sts.esc_named) begin
                  state_in = sts.last_byte ? ST_CLOSEQ : ST_IDLE;
               end else begin
                  state_in = ST_U0;
               end
            end
         end
         ST_U0: begin
            cmd.char_sel = ttyrec_pkg::CH_ZERO;
            if (sts.out_ok) begin
               cmd.emit = 1'b1;
               state_in = ST_U00;
            end
         end
         ST_U00: begin
            cmd.char_sel = ttyrec_pkg::CH_ZERO;
            if (sts.out_ok) begin
               cmd.emit = 1'b1;
               state_in = ST_HEXHI;
            end
         end
         ST_HEXHI: begin
            cmd.char_sel = ttyrec_pkg::CH_HEXHI;
            if (sts.out_ok) begin
               cmd.emit = 1'b1;
               state_in = ST_HEXLO;
            end
         end
         ST_HEXLO: begin
            cmd.char_sel = ttyrec_pkg::CH_HEXLO;
            cmd.last     = !sts.last_byte;
            if (sts.out_ok) begin
               cmd.emit = 1'b1;
               state_in = sts.last_byte ? ST_CLOSEQ : ST_IDLE;
            end
         end
         ST_CLOSEQ: begin
            cmd.char_sel = ttyrec_pkg::CH_QUOTE;
            if (sts.out_ok) begin
               cmd.emit = 1'b1;
               state_in = ST_CLOSEB;
            end
         end
         ST_CLOSEB: begin
            cmd.char_sel = ttyrec_pkg::CH_RBRACK;
            cmd.last     = 1'b1;
            if (sts.out_ok) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> tb/sv/ttyrec_record_to_json_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttyrec_record_to_json_tb
// Feeds ttyrec records (12-byte header, then payload) into the converter with
// random gaps and output back-pressure, predicts the JSON text one character
// at a time and compares every character and its end-of-run flag in order.
// ----------------------------------------------------------------------------

typedef struct {
   logic [7:0] ch;
   logic       last;
} json_char_type;

class ttyrec_json_tracker;
   logic [3:0]    hdr_idx;
   logic [31:0]   secs;
   logic [31:0]   usecs;
   logic [31:0]   bytes_left;
   bit            in_pay;
   bit            first_rec;
   json_char_type chars_due[$];
   int            mismatches;

   function new();
      hdr_idx    = '0;
      secs       = '0;
      usecs      = '0;
      bytes_left = '0;
      in_pay     = 1'b0;
      first_rec  = 1'b1;
      mismatches = 0;
   endfunction

   function int pending();
      return chars_due.size();
   endfunction

   task report(input string msg);
      mismatches++;
      $display("%0t ns mismatch: %s", $time, msg);
   endtask

   function void put(input logic [7:0] c);
      json_char_type e;
      e.ch   = c;
      e.last = 1'b0;
      chars_due.push_back(e);
   endfunction

   function void put_decimal(input logic [31:0] v);
      logic [7:0] digs[10];
      int k;
      k = 0;
      do begin
         digs[k] = ttyrec_pkg::ASC_ZERO + 8'(v % 10);
         v = v / 10;
         k++;
      end while (v != 0);
      while (k > 0) begin
         k--;
         put(digs[k]);
      end
   endfunction

   function logic [7:0] hex_digit(input logic [3:0] n);
      logic [7:0] r;
      if (n < 4'd10) begin
         r = ttyrec_pkg::ASC_ZERO + 8'(n);
      end else begin
         r = ttyrec_pkg::ASC_LOWER_A + 8'(n) - 8'd10;
      end
      return r;
   endfunction

   function void put_escaped(input logic [7:0] b);
      logic [7:0] letter;
      case (b)
         8'h00:                  letter = "0";
         ttyrec_pkg::ASC_QUOTE:  letter = ttyrec_pkg::ASC_QUOTE;
         ttyrec_pkg::ASC_BSLASH: letter = ttyrec_pkg::ASC_BSLASH;
         8'h0A:                  letter = "n";
         8'h0D:                  letter = "r";
         8'h0B:                  letter = "v";
         8'h09:                  letter = "t";
         8'h08:                  letter = "b";
         8'h0C:                  letter = "f";
         default:                letter = 8'h00;
      endcase
      if (letter != 8'h00) begin
         put(ttyrec_pkg::ASC_BSLASH);
         put(letter);
      end else if (b < ttyrec_pkg::ASC_SPACE) begin
         put(ttyrec_pkg::ASC_BSLASH);
         put(ttyrec_pkg::ASC_U);
         put(ttyrec_pkg::ASC_ZERO);
         put(ttyrec_pkg::ASC_ZERO);
         put(hex_digit(b[7:4]));
         put(hex_digit(b[3:0]));
      end else begin
         put(b);
      end
   endfunction

   function void take_stream_byte(input logic [7:0] b);
      int start;
      start = chars_due.size();
      if (in_pay) begin
         put_escaped(b);
         bytes_left--;
         if (bytes_left == 0) begin
            put(ttyrec_pkg::ASC_QUOTE);
            put(ttyrec_pkg::ASC_RBRACK);
            in_pay = 1'b0;
         end
      end else begin
         // header words are little-endian
         case (hdr_idx[3:2])
            2'd0:    secs[8*hdr_idx[1:0] +: 8] = b;
            2'd1:    usecs[8*hdr_idx[1:0] +: 8] = b;
            default: bytes_left[8*hdr_idx[1:0] +: 8] = b;
         endcase
         if (hdr_idx != ttyrec_pkg::HDR_LAST_IDX) begin
            hdr_idx++;
            return;
         end
         hdr_idx = '0;
         if (!first_rec) put(ttyrec_pkg::ASC_COMMA);
         first_rec = 1'b0;
         put(ttyrec_pkg::ASC_LBRACK);
         put_decimal(secs);
         put(ttyrec_pkg::ASC_COMMA);
         put_decimal(usecs);
         put(ttyrec_pkg::ASC_COMMA);
         put(ttyrec_pkg::ASC_QUOTE);
         if (bytes_left == 0) begin
            put(ttyrec_pkg::ASC_QUOTE);
            put(ttyrec_pkg::ASC_RBRACK);
         end else begin
            in_pay = 1'b1;
         end
      end
      if (chars_due.size() > start) chars_due[chars_due.size() - 1].last = 1'b1;
   endfunction

   task match_char(input logic [7:0] ch, input logic last);
      json_char_type e;
      if (chars_due.size() == 0) begin
         report($sformatf("unexpected char 8'h%02h", ch));
         return;
      end
      e = chars_due.pop_front();
      if (ch !== e.ch) report($sformatf("char 8'h%02h, want 8'h%02h", ch, e.ch));
      if (last !== e.last) report($sformatf("last_of_run %b, want %b on 8'h%02h",
                                            last, e.last, e.ch));
   endtask
endclass

module ttyrec_record_to_json_tb;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;

   bit tx_gaps_on;
   bit rx_gaps_on;
   bit rx_hold;
   bit hold_go;
   int words_sent;

   ttyrec_json_tracker trk;

   ttyrec_record_to_json dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // long receiver hold-off, counted here once the stimulus asks for it
   initial begin : hold
      rx_hold = 1'b0;
      wait (hold_go);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // Watches both channels at the edge; input is noted before output is
   // checked so ordering within a step never matters. Also drives rsp_stall.
   initial begin : watch
      int gap;
      gap       = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (req_valid && !req_stall) trk.take_stream_byte(req_in_byte);
            if (rsp_valid && !rsp_stall) begin
               trk.match_char(rsp_out_byte, rsp_last_of_run);
               gap = rx_gaps_on ? $urandom_range(0, 14) : 0;
            end else if (gap > 0) begin
               gap--;
            end
            rsp_stall <= (gap > 0) || rx_hold;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = tx_gaps_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_header(input logic [31:0] s, input logic [31:0] u,
                              input logic [31:0] len);
      for (int i = 0; i < 4; i++) send_byte(s[8*i +: 8]);
      for (int i = 0; i < 4; i++) send_byte(u[8*i +: 8]);
      for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8]);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (trk.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_stamp();
      logic [31:0] p;
      logic [31:0] r;
      p = 1;
      case ($urandom_range(0, 5))
         0: r = '0;
         1: r = '1;
         2: r = $urandom;
         3: r = $urandom_range(0, 9);
         4: begin
            // powers of ten and one below, to hit digit-count boundaries
            repeat ($urandom_range(1, 9)) p = p * 10;
            r = p - $urandom_range(0, 1);
         end
         default: r = $urandom_range(0, 999999);
      endcase
      return r;
   endfunction

   function automatic logic [7:0] pick_payload();
      logic [7:0] named[10] = '{8'h00, 8'h22, 8'h5C, 8'h0A, 8'h0D,
                                8'h0B, 8'h09, 8'h08, 8'h0C, 8'h1F};
      logic [7:0] r;
      case ($urandom_range(0, 9))
         0, 1:    r = named[$urandom_range(0, 9)];
         2, 3:    r = 8'($urandom_range(0, 31));
         4:       r = 8'($urandom_range(128, 255));
         default: r = 8'($urandom_range(0, 255));
      endcase
      return r;
   endfunction

   initial begin : stim
      logic [7:0] probe[13] = '{8'h00, 8'h22, 8'h5C, 8'h0A, 8'h0D, 8'h0B, 8'h09,
                                8'h08, 8'h0C, 8'h01, 8'h1F, 8'h20, 8'hFF};
      int len;
      bit paused;
      trk         = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = 8'h00;
      tx_gaps_on  = 1'b1;
      rx_gaps_on  = 1'b1;
      words_sent  = 0;
      paused      = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // first record: no comma, max and zero stamps, every escape class
      send_header(32'hFFFF_FFFF, 32'h0, 32'd13);
      foreach (probe[i]) send_byte(probe[i]);

      // receiver holds off long enough for the block to back up into req
      hold_go = 1'b1;
      send_header(pick_stamp(), pick_stamp(), 32'd8);
      repeat (8) send_byte(pick_payload());

      while (words_sent < 150) begin
         if ($urandom_range(0, 3) == 0) tx_gaps_on = !tx_gaps_on;
         if ($urandom_range(0, 3) == 0) rx_gaps_on = !rx_gaps_on;
         if (!paused && words_sent > 90) begin
            wait_drained();
            paused = 1'b1;
         end
         len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         send_header(pick_stamp(), pick_stamp(), len);
         repeat (len) send_byte(pick_payload());
      end

      // stream ends inside a record with a huge length
      send_header(pick_stamp(), pick_stamp(), $urandom | 32'h0101_0101);
      repeat (3) send_byte(pick_payload());
      req_valid <= 1'b0;

      @(posedge clock);
      while (trk.pending() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (trk.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
